// File: hdl/clcd_pkg.sv
// ----------------------------------------------------------------------------
// clcd_pkg: shared types and constants for the character LCD bus sequencer
// Phase codes, queue entry layout, beat widths and the init command list.
// ----------------------------------------------------------------------------
`default_nettype none

package clcd_pkg;

   // Beat widths on the stream and register ports
   localparam int REQ_DATA_W  = 24;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // Request kinds
   localparam logic [1:0] TYPE_DATA = 2'd0;
   localparam logic [1:0] TYPE_CMD  = 2'd1;
   localparam logic [1:0] TYPE_POS  = 2'd2;

   // Display rows that act on a position request
   localparam logic [1:0] ROW_ONE = 2'd1;
   localparam logic [1:0] ROW_TWO = 2'd2;

   // DDRAM address bases for the two rows
   localparam logic [7:0] ROW_ONE_BASE = 8'h80;
   localparam logic [7:0] ROW_TWO_BASE = 8'hC0;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SETUP     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUSY_HOLD = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_POWERUP   = 2'd2;

   // Register reset values
   localparam logic [7:0]  SETUP_RESET     = 8'd2;
   localparam logic [15:0] BUSY_HOLD_RESET = 16'd5000;
   localparam logic [15:0] POWERUP_RESET   = 16'd15000;

   localparam logic [15:0] DELAY_MAX = 16'hFFFF;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      PH_POWERUP,
      PH_IDLE,
      PH_BHOLD,
      PH_BDROP,
      PH_WSET,
      PH_WDATA,
      PH_WENH
   } phase_type;

   // One classified request beat
   typedef struct packed {
      logic       tick;
      logic       valid;
      logic       start;   // a byte goes out for this request
      logic       rs_bit;
      logic [7:0] data;
      logic       busy;
   } item_type;

   // Power-up list: clear, 8-bit 2-line mode x3, display on, clear, entry mode, home
   function automatic logic [7:0] init_byte(input logic [2:0] idx);
      logic [7:0] b;
      unique case (idx)
         3'd0: b = 8'h01;
         3'd1: b = 8'h38;
         3'd2: b = 8'h38;
         3'd3: b = 8'h38;
         3'd4: b = 8'h0E;
         3'd5: b = 8'h01;
         3'd6: b = 8'h06;
         3'd7: b = 8'h80;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// File: hdl/clcd_front.sv
// ----------------------------------------------------------------------------
// clcd_front: request intake and classification
// Unpacks a request beat, works out the byte and RS for it and whether
// anything goes out, and pushes the result into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_front (
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [clcd_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic [clcd_pkg::REQ_USER_W-1:0]   req_tuser,
   input  wire logic                              q_full,
   output logic                                   q_push,
   output clcd_pkg::item_type                     q_item
);
   import clcd_pkg::*;

   logic       f_tick;
   logic       f_valid;
   logic [7:0] f_byte;
   logic [1:0] f_row;
   logic [5:0] f_col;
   logic       f_busy;
   logic [7:0] pos_byte;
   logic       row_ok;

   assign f_tick  = req_tdata[0];
   assign f_valid = req_tdata[1];
   assign f_byte  = req_tdata[9:2];
   assign f_row   = req_tdata[11:10];
   assign f_col   = req_tdata[17:12];
   assign f_busy  = req_tdata[18];

   assign row_ok   = (f_row == ROW_ONE) || (f_row == ROW_TWO);
   // column counts from 1; wraps modulo 256
   assign pos_byte = ((f_row == ROW_ONE) ? ROW_ONE_BASE : ROW_TWO_BASE)
                     + {2'b00, f_col} - 8'd1;

   always_comb begin
      q_item.tick   = f_tick;
      q_item.valid  = f_valid;
      q_item.busy   = f_busy;
      q_item.start  = 1'b0;
      q_item.rs_bit = 1'b0;
      q_item.data   = f_byte;
      unique case (req_tuser)
         TYPE_DATA: begin
            q_item.start  = f_valid;
            q_item.rs_bit = 1'b1;
         end
         TYPE_CMD: begin
            q_item.start = f_valid;
         end
         TYPE_POS: begin
            q_item.start = f_valid && row_ok;
            q_item.data  = pos_byte;
         end
         default: begin
            q_item.start = 1'b0;
         end
      endcase
   end

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

endmodule

`default_nettype wire

// File: hdl/clcd_queue.sv
// ----------------------------------------------------------------------------
// clcd_queue: short FIFO between intake and sequencer
// Holds classified beats so intake keeps going while the output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire clcd_pkg::item_type  push_item,
   output logic                     full,
   input  wire logic                pop,
   output logic                     not_empty,
   output clcd_pkg::item_type       head_item
);
   import clcd_pkg::*;

   item_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;

   assign full      = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// File: hdl/clcd_back.sv
// ----------------------------------------------------------------------------
// clcd_back: pin sequencer
// Runs one sequencer cycle per queued beat: power-up wait, init list,
// busy poll and write strobe, and registers the pin values for the beat.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_back #(
   parameter int INIT_LENGTH = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 q_not_empty,
   input  wire clcd_pkg::item_type                   q_head,
   output logic                                      q_pop,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [clcd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [clcd_pkg::CSR_DATA_W-1:0]      csr_data,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [clcd_pkg::RSP_DATA_W-1:0]           rsp_tdata
);
   import clcd_pkg::*;

   localparam logic [3:0] INIT_LAST = 4'(INIT_LENGTH);

   // configuration
   logic [7:0]  setup_ff;
   logic [15:0] hold_ff;
   logic [15:0] pwr_ff;

   // sequencer state
   phase_type   phase_ff, phase_in;
   logic [15:0] delay_ff, delay_in;
   logic [7:0]  byte_ff,  byte_in;
   logic        rs_ff,    rs_in;
   logic [3:0]  step_ff,  step_in;
   logic        fin_ff,   fin_in;

   // output stage
   logic                  out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff,  out_data_in;

   logic [15:0] target;
   logic        t_done;
   logic [15:0] t_count;
   logic [3:0]  step_inc;

   logic       p_rs, p_rw, p_en, p_drive, p_ready;
   logic [7:0] p_bus;

   assign q_pop     = q_not_empty && (!out_valid_ff || rsp_tready);
   assign csr_ready = 1'b1;

   // timed-step counter shared by all phases
   always_comb begin
      unique case (phase_ff)
         PH_POWERUP: target = pwr_ff;
         PH_BHOLD:   target = hold_ff;
         default:    target = {8'h00, setup_ff};
      endcase
      t_done = (delay_ff >= target);
      if (t_done) begin
         t_count = '0;
      end else if (q_head.tick && delay_ff != DELAY_MAX) begin
         t_count = delay_ff + 16'd1;
      end else begin
         t_count = delay_ff;
      end
   end

   assign step_inc = step_ff + 4'd1;

   // next state
   always_comb begin
      phase_in = phase_ff;
      delay_in = t_count;
      byte_in  = byte_ff;
      rs_in    = rs_ff;
      step_in  = step_ff;
      fin_in   = fin_ff;
      unique case (phase_ff)
         PH_POWERUP: begin
            if (t_done) begin
               step_in  = '0;
               byte_in  = init_byte(3'd0);
               rs_in    = 1'b0;
               phase_in = PH_BHOLD;
            end
         end
         PH_BHOLD: begin
            if (t_done) begin
               phase_in = q_head.busy ? PH_BDROP : PH_WSET;
            end
         end
         PH_BDROP: begin
            delay_in = '0;
            phase_in = PH_BHOLD;
         end
         PH_WSET: begin
            if (t_done) begin
               phase_in = PH_WDATA;
            end
         end
         PH_WDATA: begin
            if (t_done) begin
               phase_in = PH_WENH;
            end
         end
         PH_WENH: begin
            if (t_done) begin
               if (!fin_ff) begin
                  step_in = step_inc;
                  if (step_inc >= INIT_LAST) begin
                     fin_in   = 1'b1;
                     phase_in = PH_IDLE;
                  end else begin
                     byte_in  = init_byte(step_inc[2:0]);
                     rs_in    = 1'b0;
                     phase_in = PH_BHOLD;
                  end
               end else begin
                  phase_in = PH_IDLE;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
            delay_in = '0;
            if (q_head.start) begin
               byte_in  = q_head.data;
               rs_in    = q_head.rs_bit;
               phase_in = PH_BHOLD;
            end
         end
      endcase
   end

   // pin values of the current phase
   always_comb begin
      p_rs    = 1'b0;
      p_rw    = 1'b0;
      p_en    = 1'b0;
      p_bus   = 8'h00;
      p_drive = 1'b0;
      p_ready = 1'b0;
      unique case (phase_ff)
         PH_POWERUP: begin
            p_drive = 1'b0;
         end
         PH_BHOLD: begin
            p_rw = 1'b1;
            p_en = 1'b1;
         end
         PH_BDROP: begin
            p_rw = 1'b1;
         end
         PH_WSET: begin
            p_rs = rs_ff;
         end
         PH_WDATA: begin
            p_rs    = rs_ff;
            p_bus   = byte_ff;
            p_drive = 1'b1;
         end
         PH_WENH: begin
            p_rs    = rs_ff;
            p_bus   = byte_ff;
            p_drive = 1'b1;
            p_en    = 1'b1;
         end
         default: begin
            p_rs    = rs_ff;
            p_bus   = byte_ff;
            p_drive = 1'b1;
            p_ready = q_head.valid;
         end
      endcase
   end

   always_comb begin
      out_data_in  = {2'b00, fin_ff, p_ready, p_drive, p_bus, p_en, p_rw, p_rs};
      out_valid_in = q_pop ? 1'b1 : (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_POWERUP;
         delay_ff     <= '0;
         byte_ff      <= '0;
         rs_ff        <= 1'b0;
         step_ff      <= '0;
         fin_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (q_pop) begin
            phase_ff <= phase_in;
            delay_ff <= delay_in;
            byte_ff  <= byte_in;
            rs_ff    <= rs_in;
            step_ff  <= step_in;
            fin_ff   <= fin_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         out_data_ff <= out_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_ff <= SETUP_RESET;
         hold_ff  <= BUSY_HOLD_RESET;
         pwr_ff   <= POWERUP_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SETUP:     setup_ff <= csr_data[7:0];
            CSR_BUSY_HOLD: hold_ff  <= csr_data;
            CSR_POWERUP:   pwr_ff   <= csr_data;
            default:       setup_ff <= setup_ff;
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // once the init list is out it stays out
   a_fin_sticky: assert property (@(posedge clock) disable iff (reset)
      fin_ff |=> fin_ff)
      else $error("init_done dropped");

   // idle is only reached after the init list
   a_idle_after_init: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> fin_ff)
      else $error("idle before init list finished");

   // sequencer advances only on a popped beat
   a_hold_without_pop: assert property (@(posedge clock) disable iff (reset)
      !q_pop |=> $stable(phase_ff) && $stable(delay_ff) && $stable(step_ff))
      else $error("sequencer moved without a beat");

   // a fresh result is captured whenever a beat is popped
   a_pop_gives_result: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> out_valid_ff)
      else $error("popped beat produced no result");

endmodule

`default_nettype wire

// File: hdl/char_lcd_parallel_interface.sv
// ----------------------------------------------------------------------------
// char_lcd_parallel_interface: 8-bit character LCD bus sequencer
// Each request beat is one cycle of the pin sequencer; each response beat
// carries the display pin values for that cycle.
// ----------------------------------------------------------------------------
// Usage:
//   req_* beats carry the per-cycle inputs: microsecond tick, request
//   valid/kind (kind in tuser), byte, row, column and the sampled busy flag.
//   rsp_* returns one beat per request beat with RS, RW, EN, the data byte,
//   bus drive, request-taken flag and init-done flag.
//   csr_* writes setup, busy-hold and power-up tick counts; write only while
//   no beats are in flight. csr_ready is always high.
// Timing:
//   An accepted request beat goes into the queue; its result is registered
//   when the sequencer pops it. One beat per cycle is sustained while
//   rsp_tready is high; a step does the timer compare and phase update.
// Reset and stalls:
//   Reset puts the sequencer in the power-up wait and restores register
//   defaults. When rsp_tready is low the result is held and up to four
//   request beats queue up; after that req_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_parallel_interface #(
   parameter int INIT_LENGTH = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // tdata: us_tick[0], req_valid[1], byte_in[9:2], row[11:10],
   //        column[17:12], busy_in[18], zero[23:19]
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [clcd_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: req_type[1:0]
   input  wire logic [clcd_pkg::REQ_USER_W-1:0]     req_tuser,
   // tdata: rs[0], rw[1], en[2], bus_out[10:3], bus_drive[11],
   //        ready_res[12], init_done[13], zero[15:14]
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [clcd_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [clcd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [clcd_pkg::CSR_DATA_W-1:0]     csr_data
);
   import clcd_pkg::*;

   logic     q_full;
   logic     q_push;
   logic     q_pop;
   logic     q_not_empty;
   item_type push_item;
   item_type head_item;

   clcd_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   clcd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_item (head_item)
   );

   clcd_back #(
      .INIT_LENGTH (INIT_LENGTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (head_item),
      .q_pop       (q_pop),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

`default_nettype wire

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: character LCD bus sequencer testbench
// Streams per-cycle sequencer beats into the block, tracks the expected pin
// values with a cycle model of the power-up wait, init list, busy polling and
// byte write, and compares every result beat field by field. Covers the init
// list, every request kind, the position wrap, ignored rows and kinds, and
// large and zero values of the three timing registers.
// ----------------------------------------------------------------------------

module tb_top;
   import clcd_pkg::*;

   localparam logic [1:0] TYPE_SPARE = 2'd3;
   localparam logic [1:0] ROW_ZERO   = 2'd0;
   localparam logic [1:0] ROW_THREE  = 2'd3;
   localparam int IDLE_PCT     = 17;
   localparam int RANDOM_BEATS = 700;
   localparam int INIT_LEN     = 8;
   // init commands, entry 0 in the low byte
   localparam logic [63:0] INIT_CMDS =
      {8'h80, 8'h06, 8'h01, 8'h0E, 8'h38, 8'h38, 8'h38, 8'h01};

   typedef struct packed {
      logic       tick;
      logic       valid;
      logic [1:0] kind;
      logic [7:0] data;
      logic [1:0] row;
      logic [5:0] col;
      logic       busy;
   } req_beat_type;

   typedef struct packed {
      logic       rs;
      logic       rw;
      logic       en;
      logic [7:0] bus;
      logic       drive;
      logic       taken;
      logic       done;
   } pin_set_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic [REQ_USER_W-1:0]  req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // sequencer model state and its copy of the registers
   phase_type   seq_phase;
   logic [15:0] tick_count;
   logic [7:0]  held_data;
   logic        held_rs_bit;
   logic [3:0]  init_index;
   logic        init_sent;
   logic [7:0]  cfg_setup;
   logic [15:0] cfg_hold;
   logic [15:0] cfg_powerup;

   pin_set_type pending_pins[$];
   bit steady = 1'b0;
   int beats_sent = 0;
   int results_checked = 0;
   int requests_taken = 0;
   int bytes_started = 0;
   int busy_retries = 0;
   int csr_writes = 0;
   int mismatches = 0;

   char_lcd_parallel_interface i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ends the run as a failure if it hangs
   initial begin
      #1_000_000;
      $display("status: fail");
      $finish;
   end

   // ---------------------------------------------------------------- model

   function automatic bit step_elapsed(input logic [15:0] target, input logic tick);
      if (tick_count >= target) begin
         tick_count = '0;
         return 1'b1;
      end
      if (tick && tick_count != 16'hFFFF) tick_count = tick_count + 16'd1;
      return 1'b0;
   endfunction

   function automatic void load_byte(input logic [7:0] value, input logic rs_bit);
      held_data = value;
      held_rs_bit = rs_bit;
      tick_count = '0;
      seq_phase = PH_BHOLD;
      bytes_started++;
   endfunction

   // one sequencer cycle: pins come from the phase on entry, then the phase moves on
   function automatic pin_set_type lcd_seq_step(input req_beat_type b);
      pin_set_type p;
      p = '0;
      p.done = init_sent;
      unique case (seq_phase)
         PH_POWERUP: ;
         PH_BHOLD: begin
            p.rw = 1'b1;
            p.en = 1'b1;
         end
         PH_BDROP: p.rw = 1'b1;
         PH_WSET: p.rs = held_rs_bit;
         PH_WENH: begin
            p.rs = held_rs_bit;
            p.bus = held_data;
            p.drive = 1'b1;
            p.en = 1'b1;
         end
         default: begin
            p.rs = held_rs_bit;
            p.bus = held_data;
            p.drive = 1'b1;
         end
      endcase

      unique case (seq_phase)
         PH_POWERUP: begin
            if (step_elapsed(cfg_powerup, b.tick)) begin
               init_index = '0;
               load_byte(INIT_CMDS[7:0], 1'b0);
            end
         end
         PH_BHOLD: begin
            if (step_elapsed(cfg_hold, b.tick)) begin
               if (b.busy) begin
                  seq_phase = PH_BDROP;
                  busy_retries++;
               end else begin
                  seq_phase = PH_WSET;
               end
            end
         end
         PH_BDROP: begin
            tick_count = '0;
            seq_phase = PH_BHOLD;
         end
         PH_WSET: if (step_elapsed({8'h00, cfg_setup}, b.tick)) seq_phase = PH_WDATA;
         PH_WDATA: if (step_elapsed({8'h00, cfg_setup}, b.tick)) seq_phase = PH_WENH;
         PH_WENH: begin
            if (step_elapsed({8'h00, cfg_setup}, b.tick)) begin
               if (!init_sent) begin
                  init_index = init_index + 4'd1;
                  if (init_index >= 4'(INIT_LEN)) begin
                     init_sent = 1'b1;
                     seq_phase = PH_IDLE;
                  end else begin
                     load_byte(INIT_CMDS[8*init_index[2:0] +: 8], 1'b0);
                  end
               end else begin
                  seq_phase = PH_IDLE;
               end
            end
         end
         default: begin
            seq_phase = PH_IDLE;
            tick_count = '0;
            if (b.valid) begin
               p.taken = 1'b1;
               requests_taken++;
               unique case (b.kind)
                  TYPE_DATA: load_byte(b.data, 1'b1);
                  TYPE_CMD: load_byte(b.data, 1'b0);
                  TYPE_POS: begin
                     // column 0 wraps to the byte below the row base
                     if (b.row == ROW_ONE)
                        load_byte(ROW_ONE_BASE + {2'b00, b.col} - 8'd1, 1'b0);
                     else if (b.row == ROW_TWO)
                        load_byte(ROW_TWO_BASE + {2'b00, b.col} - 8'd1, 1'b0);
                  end
                  default: ;
               endcase
            end
         end
      endcase
      return p;
   endfunction

   // -------------------------------------------------------------- drivers

   always @(negedge clock) rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);

   task automatic flag_mismatch(input string what, input logic [15:0] got,
                                input logic [15:0] want);
      mismatches++;
      if (mismatches <= 40)
         $display("mismatch on result %0d: %s got 0x%0h expected 0x%0h",
                  results_checked, what, got, want);
   endtask

   always @(posedge clock) begin
      pin_set_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pins.size() == 0) begin
            flag_mismatch("unexpected result beat", rsp_tdata, 16'h0);
         end else begin
            want = pending_pins.pop_front();
            if (rsp_tdata[0] !== want.rs)
               flag_mismatch("rs", 16'(rsp_tdata[0]), 16'(want.rs));
            if (rsp_tdata[1] !== want.rw)
               flag_mismatch("rw", 16'(rsp_tdata[1]), 16'(want.rw));
            if (rsp_tdata[2] !== want.en)
               flag_mismatch("en", 16'(rsp_tdata[2]), 16'(want.en));
            if (rsp_tdata[10:3] !== want.bus)
               flag_mismatch("bus_out", 16'(rsp_tdata[10:3]), 16'(want.bus));
            if (rsp_tdata[11] !== want.drive)
               flag_mismatch("bus_drive", 16'(rsp_tdata[11]), 16'(want.drive));
            if (rsp_tdata[12] !== want.taken)
               flag_mismatch("ready_res", 16'(rsp_tdata[12]), 16'(want.taken));
            if (rsp_tdata[13] !== want.done)
               flag_mismatch("init_done", 16'(rsp_tdata[13]), 16'(want.done));
            if (rsp_tdata[15:14] !== 2'b00)
               flag_mismatch("pad", 16'(rsp_tdata[15:14]), 16'h0);
            results_checked++;
         end
      end
   end

   task automatic send_beat(input req_beat_type b);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, b.busy, b.col, b.row, b.data, b.valid, b.tick};
      req_tuser <= b.kind;
      do @(posedge clock); while (!req_tready);
      pending_pins.push_back(lcd_seq_step(b));
      beats_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_pins.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      unique case (idx)
         CSR_SETUP: cfg_setup = value[7:0];
         CSR_BUSY_HOLD: cfg_hold = value;
         CSR_POWERUP: cfg_powerup = value;
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_timing(input logic [7:0] setup, input logic [15:0] hold,
                             input logic [15:0] powerup);
      wait_drained();
      repeat (3) @(posedge clock);
      csr_write(CSR_SETUP, {8'h00, setup});
      csr_write(CSR_BUSY_HOLD, hold);
      csr_write(CSR_POWERUP, powerup);
   endtask

   function automatic req_beat_type random_beat(input int tick_pct, input int busy_pct,
                                                input int valid_pct);
      req_beat_type b;
      b.tick = $urandom_range(99) < tick_pct;
      b.busy = $urandom_range(99) < busy_pct;
      b.valid = $urandom_range(99) < valid_pct;
      b.kind = 2'($urandom_range(3));
      b.data = 8'($urandom);
      b.row = 2'($urandom_range(3));
      b.col = 6'($urandom_range(63));
      return b;
   endfunction

   // run cycles until the sequencer is back in idle; noise requests are not taken
   task automatic settle(input int tick_pct, input int busy_pct, input int noise_pct);
      while (seq_phase != PH_IDLE) send_beat(random_beat(tick_pct, busy_pct, noise_pct));
   endtask

   task automatic request(input logic [1:0] kind, input logic [7:0] data,
                          input logic [1:0] row, input logic [5:0] col,
                          input int tick_pct, input int busy_pct);
      req_beat_type b;
      settle(tick_pct, busy_pct, 25);
      b = random_beat(tick_pct, busy_pct, 100);
      b.kind = kind;
      b.data = data;
      b.row = row;
      b.col = col;
      send_beat(b);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_powerup_init();
      csr_write(CSR_SETUP, 16'd1);
      csr_write(CSR_BUSY_HOLD, 16'd2);
      csr_write(CSR_POWERUP, 16'd6);
      // requests offered during power-up and init must be refused
      settle(70, 30, 40);
   endtask

   task automatic test_directed_requests();
      request(TYPE_DATA, 8'h00, ROW_ZERO, 6'd0, 80, 20);
      request(TYPE_DATA, 8'hFF, ROW_THREE, 6'd63, 80, 20);
      request(TYPE_CMD, 8'h01, ROW_ONE, 6'd1, 80, 20);
      request(TYPE_CMD, 8'hAA, ROW_TWO, 6'd40, 80, 20);
      request(TYPE_POS, 8'h00, ROW_ONE, 6'd1, 80, 20);
      request(TYPE_POS, 8'hFF, ROW_ONE, 6'd40, 80, 20);
      request(TYPE_POS, 8'h00, ROW_TWO, 6'd1, 80, 20);
      request(TYPE_POS, 8'h00, ROW_TWO, 6'd40, 80, 20);
      request(TYPE_POS, 8'h00, ROW_ONE, 6'd0, 80, 20);
      request(TYPE_POS, 8'h00, ROW_TWO, 6'd63, 80, 20);
      // ignored rows and the spare kind leave the sequencer in idle
      request(TYPE_POS, 8'h00, ROW_ZERO, 6'd5, 80, 20);
      request(TYPE_POS, 8'h00, ROW_THREE, 6'd5, 80, 20);
      request(TYPE_SPARE, 8'hFF, ROW_ONE, 6'd5, 80, 20);
      request(TYPE_DATA, 8'h41, ROW_ONE, 6'd1, 80, 20);
      request(TYPE_DATA, 8'h7E, ROW_TWO, 6'd2, 80, 20);
   endtask

   task automatic test_timing_extremes();
      settle(80, 20, 25);
      // long write steps: setup count with its top bit set
      set_timing(8'd128, 16'd0, 16'hFFFF);
      request(TYPE_DATA, 8'h5A, ROW_ONE, 6'd1, 100, 30);
      settle(100, 30, 20);
      // busy hold count past the low byte of the counter
      set_timing(8'd0, 16'h0101, 16'd0);
      request(TYPE_CMD, 8'hC3, ROW_ONE, 6'd1, 100, 0);
      settle(100, 0, 20);
      // zero counts: every step ends without waiting for a tick
      set_timing(8'd0, 16'd0, 16'd0);
      request(TYPE_DATA, 8'h3C, ROW_ONE, 6'd1, 0, 60);
      settle(0, 60, 20);
   endtask

   task automatic test_random_traffic();
      int quota;
      int round;
      int pick;
      req_beat_type b;
      for (round = 0; round < 4; round++) begin
         settle(80, 20, 25);
         unique case (round)
            0: set_timing(8'd0, 16'd0, 16'd0);
            1: set_timing(8'd1, 16'd1, 16'hFFFF);
            2: set_timing(8'd3, 16'd2, 16'd100);
            default: set_timing(8'($urandom_range(4)), 16'($urandom_range(6)),
                                16'($urandom));
         endcase
         steady = (round == 2);
         quota = beats_sent + RANDOM_BEATS / 4;
         while (beats_sent < quota) begin
            if ($urandom_range(99) < 2) wait_drained();
            b = random_beat(80, 20, 25);
            if (seq_phase == PH_IDLE) begin
               b.valid = $urandom_range(99) < 85;
               pick = $urandom_range(99);
               if (pick < 40) b.kind = TYPE_DATA;
               else if (pick < 65) b.kind = TYPE_CMD;
               else if (pick < 95) b.kind = TYPE_POS;
               else b.kind = TYPE_SPARE;
               if ($urandom_range(99) < 85) b.row = 2'($urandom_range(1, 2));
               if ($urandom_range(99) < 85) b.col = 6'($urandom_range(1, 40));
            end
            send_beat(b);
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      int guard;
      seq_phase = PH_POWERUP;
      tick_count = '0;
      held_data = '0;
      held_rs_bit = 1'b0;
      init_index = '0;
      init_sent = 1'b0;
      cfg_setup = 8'd2;
      cfg_hold = 16'd5000;
      cfg_powerup = 16'd15000;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_powerup_init();
      test_directed_requests();
      test_timing_extremes();
      test_random_traffic();

      @(negedge clock);
      req_tvalid <= 1'b0;
      guard = 0;
      while (pending_pins.size() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);
      if (pending_pins.size() != 0)
         flag_mismatch("results never returned", 16'(pending_pins.size()), 16'h0);

      $display("covered %0d sequencer cycles, %0d requests taken, %0d bytes sent to the display",
               beats_sent, requests_taken, bytes_started);
      $display("busy retries %0d, register writes %0d, results checked %0d, mismatches %0d",
               busy_retries, csr_writes, results_checked, mismatches);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
